// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the sprite frame select top-level module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sprite frame select: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sprite frame select: next-cycle check failed");

`endif

// ----- hdl/sff_pkg.sv -----
// ----------------------------------------------------------------------------
// sff_pkg
// Types and constants shared by the sprite frame select modules.
// ----------------------------------------------------------------------------
package sff_pkg;

   localparam int DATA_W   = 32;
   localparam int SPRITE_W = 16;
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 2;

   localparam logic [INDEX_W-1:0] CSR_ANIM_DURATION = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_PLAYBACK_MODE = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_FIRST_SPRITE  = 2'd2;
   localparam logic [INDEX_W-1:0] CSR_LAST_SPRITE   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0]   anim_duration;
      logic [MODE_W-1:0]   playback_mode;
      logic [SPRITE_W-1:0] first_sprite;
      logic [SPRITE_W-1:0] last_sprite;
   } cfg_type;

endpackage

// ----- hdl/sff_div_stage.sv -----
// ----------------------------------------------------------------------------
// sff_div_stage
// One registered step of the restoring divider: shifts one dividend bit into
// the partial remainder, subtracts the divisor when it fits and records the
// quotient bit.
// ----------------------------------------------------------------------------
module sff_div_stage #(
   parameter int TW = 32,
   parameter int QW = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic [TW-1:0] dur,
   input  logic          valid_i,
   input  logic [TW-1:0] num_i,
   input  logic [TW-1:0] rem_i,
   input  logic [QW-1:0] quo_i,
   output logic          valid_o,
   output logic [TW-1:0] num_o,
   output logic [TW-1:0] rem_o,
   output logic [QW-1:0] quo_o
);

   logic [TW:0]   shifted;
   logic [TW-1:0] diff;
   logic          fits;
   logic          valid_ff, valid_in;
   logic [TW-1:0] num_ff, num_in;
   logic [TW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;

   always_comb begin
      shifted  = {rem_i, num_i[TW-1]};
      diff     = shifted[TW-1:0] - dur;
      fits     = (shifted >= {1'b0, dur});
      valid_in = valid_i;
      num_in   = {num_i[TW-2:0], 1'b0};
      rem_in   = fits ? diff : shifted[TW-1:0];
      quo_in   = {quo_i[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign valid_o = valid_ff;
   assign num_o   = num_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;

endmodule

// ----- hdl/sff_blend.sv -----
// ----------------------------------------------------------------------------
// sff_blend
// Applies the playback rule to the quotient, scales the sprite span by the
// resulting position and rounds to the sprite index, in three stages.
// ----------------------------------------------------------------------------
module sff_blend #(
   parameter int TW        = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  sff_pkg::cfg_type                  cfg,
   input  logic                              valid_i,
   input  logic [TW+FRAC_BITS-1:0]           quo_i,
   output logic                              valid_o,
   output logic [sff_pkg::SPRITE_W-1:0]      sprite_index
);

   localparam int TVW = FRAC_BITS + 1;
   localparam int PW  = sff_pkg::SPRITE_W + TVW;
   localparam int AW  = PW + 1;
   localparam logic [TVW-1:0] T_ONE  = TVW'(1) << FRAC_BITS;
   localparam logic [AW-1:0]  T_HALF = AW'(1) << (FRAC_BITS - 1);

   logic [TW-1:0]                whole;
   logic [FRAC_BITS-1:0]         frac;
   logic                         over;
   logic                         rising;
   logic                         zero_dur;
   logic [sff_pkg::SPRITE_W-1:0] span;
   logic [AW-1:0]                base;
   logic [AW-1:0]                acc;
   logic [2:0]                   valid_ff, valid_in;
   logic [TVW-1:0]               tv_ff, tv_in;
   logic [PW-1:0]                prod_ff, prod_in;
   logic [sff_pkg::SPRITE_W-1:0] idx_ff, idx_in;

   always_comb begin
      whole    = quo_i[TW+FRAC_BITS-1:FRAC_BITS];
      frac     = quo_i[FRAC_BITS-1:0];
      over     = (|whole[TW-1:1]) || (whole[0] && (|frac));
      rising   = (cfg.last_sprite >= cfg.first_sprite);
      zero_dur = (cfg.anim_duration[TW-1:0] == '0);
      span     = rising ? (cfg.last_sprite - cfg.first_sprite)
                        : (cfg.first_sprite - cfg.last_sprite);
      base     = AW'({cfg.first_sprite, {FRAC_BITS{1'b0}}});

      if (!over) begin
         tv_in = {whole[0], frac};
      end else begin
         case (cfg.playback_mode)
            sff_pkg::MODE_LOOP:     tv_in = {1'b0, frac};
            sff_pkg::MODE_PINGPONG: tv_in = whole[0] ? (T_ONE - {1'b0, frac})
                                                     : {1'b0, frac};
            default:                tv_in = T_ONE;
         endcase
      end

      prod_in = PW'(span) * PW'(tv_ff);
      acc     = (rising ? (base + AW'(prod_ff)) : (base - AW'(prod_ff))) + T_HALF;
      idx_in  = zero_dur ? '0 : acc[FRAC_BITS+sff_pkg::SPRITE_W-1:FRAC_BITS];
      valid_in = {valid_ff[1:0], valid_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tv_ff   <= tv_in;
         prod_ff <= prod_in;
         idx_ff  <= idx_in;
      end
   end

   assign valid_o      = valid_ff[2];
   assign sprite_index = idx_ff;

endmodule

// ----- hdl/sprite_frame_from_time.sv -----
// ----------------------------------------------------------------------------
// sprite_frame_from_time
// Selects the sprite frame to show for an elapsed time, with play-once,
// loop and ping-pong playback.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one elapsed time per transaction in req_tdata.
// The rsp_ channel returns one sprite index per transaction, in order.
// The csr_ channel writes the duration, playback mode and first and last
// sprite; it is always ready and should be written while no transaction is
// in flight.
// The pipeline has one stage per quotient bit of the restoring divider, then
// one stage each for the playback rule, the span multiply and the final
// rounding sum.
// A new transaction is accepted every cycle while the receiver does not stall.
// Reset empties the pipeline and clears the configuration registers to zero.
// When the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_frame_from_time #(
   parameter int FRAC_BITS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sff_pkg::DATA_W-1:0]          req_tdata,   // [31:0] elapsed_time
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sff_pkg::SPRITE_W-1:0]        rsp_tdata,   // [15:0] sprite_index
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sff_pkg::INDEX_W-1:0]         csr_index,
   input  logic [sff_pkg::DATA_W-1:0]          csr_data
);

   localparam int TW = (TIME_BITS < sff_pkg::DATA_W) ? TIME_BITS : sff_pkg::DATA_W;
   localparam int QW = TW + FRAC_BITS;
   localparam int NS = QW;

   sff_pkg::cfg_type cfg_ff, cfg_in;
   logic             en;
   logic             valid_pipe [0:NS];
   logic [TW-1:0]    num_pipe   [0:NS];
   logic [TW-1:0]    rem_pipe   [0:NS];
   logic [QW-1:0]    quo_pipe   [0:NS];
   logic [TW-1:0]    dur;
   logic [sff_pkg::SPRITE_W-1:0] lo_sprite, hi_sprite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sff_pkg::CSR_ANIM_DURATION: cfg_in.anim_duration = csr_data;
            sff_pkg::CSR_PLAYBACK_MODE:
               cfg_in.playback_mode = csr_data[sff_pkg::MODE_W-1:0];
            sff_pkg::CSR_FIRST_SPRITE:
               cfg_in.first_sprite = csr_data[sff_pkg::SPRITE_W-1:0];
            sff_pkg::CSR_LAST_SPRITE:
               cfg_in.last_sprite = csr_data[sff_pkg::SPRITE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign dur        = cfg_ff.anim_duration[TW-1:0];

   assign valid_pipe[0] = req_tvalid;
   assign num_pipe[0]   = req_tdata[TW-1:0];
   assign rem_pipe[0]   = '0;
   assign quo_pipe[0]   = '0;

   for (genvar s = 0; s < NS; s++) begin : g_div
      sff_div_stage #(
         .TW (TW),
         .QW (QW)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .dur     (dur),
         .valid_i (valid_pipe[s]),
         .num_i   (num_pipe[s]),
         .rem_i   (rem_pipe[s]),
         .quo_i   (quo_pipe[s]),
         .valid_o (valid_pipe[s+1]),
         .num_o   (num_pipe[s+1]),
         .rem_o   (rem_pipe[s+1]),
         .quo_o   (quo_pipe[s+1])
      );
   end

   sff_blend #(
      .TW        (TW),
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cfg          (cfg_ff),
      .valid_i      (valid_pipe[NS]),
      .quo_i        (quo_pipe[NS]),
      .valid_o      (rsp_tvalid),
      .sprite_index (rsp_tdata)
   );

   assign lo_sprite = (cfg_ff.last_sprite < cfg_ff.first_sprite) ? cfg_ff.last_sprite
                                                                 : cfg_ff.first_sprite;
   assign hi_sprite = (cfg_ff.last_sprite < cfg_ff.first_sprite) ? cfg_ff.first_sprite
                                                                 : cfg_ff.last_sprite;

   `SFF_ASSERT_IMP(a_stall_blocks_input, clock, reset,
      rsp_tvalid && !rsp_tready, !req_tready)
   `SFF_ASSERT_NEXT(a_accept_enters_pipe, clock, reset,
      req_tvalid && req_tready, valid_pipe[1])
   `SFF_ASSERT_IMP(a_zero_duration_index, clock, reset,
      rsp_tvalid && (dur == '0), rsp_tdata == '0)
   `SFF_ASSERT_IMP(a_index_in_range, clock, reset,
      rsp_tvalid && (dur != '0), (rsp_tdata >= lo_sprite) && (rsp_tdata <= hi_sprite))

endmodule
